### rtl/core/sjgi_pkg.sv
// shared types and constants for the shift-jis glyph index decoder
// no dependencies; imported by every module of the block
`default_nettype none

package sjgi_pkg;

    localparam int ROW_CELLS     = 94;
    localparam int ABSENT_RANGES = 18;
    localparam int FONT_GLYPHS   = 6877;
    localparam int IDX_W         = 14;

    // shift-jis byte classes and offsets
    localparam logic [7:0] LEAD_LO_MIN  = 8'h80;
    localparam logic [7:0] LEAD_LO_END  = 8'hA0;
    localparam logic [7:0] LEAD_HI_MIN  = 8'hE0;
    localparam logic [7:0] CTRL_END     = 8'h20;
    localparam logic [7:0] ASCII_END    = 8'h80;
    localparam logic [7:0] ASCII_OFS    = 8'h20;
    localparam logic [7:0] KANA_OFS     = 8'h40;
    localparam logic [7:0] HIGH_SHIFT   = 8'h40;
    localparam logic [7:0] LEAD_BASE    = 8'h81;
    localparam logic [7:0] TRAIL_SPLIT  = 8'h9E;
    localparam logic [15:0] TRAIL_UP    = 16'h0062;
    localparam logic [15:0] TRAIL_DOWN  = 16'h0040;
    localparam logic [15:0] EUC_OFS     = 16'h2121 + 16'h8080;
    localparam logic [7:0] EUC_BASE     = 8'hA1;

    // absent code ranges, ascending and disjoint
    localparam logic [15:0] ABSENT_START [ABSENT_RANGES] = '{
        16'hA2AF, 16'hA2C2, 16'hA2D1, 16'hA2EB, 16'hA2FA, 16'hA3A1, 16'hA3BA,
        16'hA3DB, 16'hA3FB, 16'hA4F4, 16'hA5F7, 16'hA6B9, 16'hA6D9, 16'hA7C2,
        16'hA7F2, 16'hA8C1, 16'hCFD4, 16'hF4A5
    };
    localparam logic [10:0] ABSENT_COUNT [ABSENT_RANGES] = '{
        11'd11, 11'd8, 11'd11, 11'd7, 11'd4, 11'd15, 11'd7, 11'd6, 11'd4,
        11'd11, 11'd8, 11'd8, 11'd38, 11'd15, 11'd13, 11'd720, 11'd43, 11'd1030
    };
    // running total of counts through each range
    localparam logic [10:0] ABSENT_CUM [ABSENT_RANGES] = '{
        11'd11, 11'd19, 11'd30, 11'd37, 11'd41, 11'd56, 11'd63, 11'd69, 11'd73,
        11'd84, 11'd92, 11'd100, 11'd138, 11'd153, 11'd166, 11'd886, 11'd929,
        11'd1959
    };

    typedef struct packed {
        logic       full;
        logic [7:0] lead;
        logic [7:0] trail;
        logic [7:0] half_idx;
    } t_s1;

    typedef struct packed {
        logic             full;
        logic [IDX_W-1:0] idx;
        logic             missing;
    } t_glyph;

endpackage

`default_nettype wire

### rtl/core/sjgi_byte_front.sv
// byte front end: accepts text bytes, holds a pending lead byte, and loads
// the input register with one character item; uses sjgi_pkg
`default_nettype none

module sjgi_byte_front
    import sjgi_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_take,
    output logic            o_s1_valid,
    output t_s1             o_s1
);

    logic [7:0] r_lead;
    logic [7:0] n_lead;
    logic       r_s1_valid;
    logic       n_s1_valid;
    t_s1        r_s1;
    t_s1        n_s1;
    logic       accept;
    logic       is_lead;
    logic       emit;

    assign o_ready = !r_s1_valid || i_take;
    assign accept  = i_valid && o_ready;
    assign is_lead = (i_text_byte >= LEAD_LO_MIN && i_text_byte < LEAD_LO_END)
                     || (i_text_byte >= LEAD_HI_MIN);

    always_comb begin
        n_lead        = r_lead;
        n_s1          = r_s1;
        emit          = 1'b0;
        n_s1.lead     = r_lead;
        n_s1.trail    = i_text_byte;
        n_s1.full     = 1'b0;
        n_s1.half_idx = 8'd0;
        if (i_text_byte == 8'd0) begin
            n_lead = 8'd0;
        end else if (r_lead != 8'd0) begin
            n_lead    = 8'd0;
            n_s1.full = 1'b1;
            emit      = 1'b1;
        end else if (is_lead) begin
            n_lead = i_text_byte;
        end else begin
            emit = 1'b1;
            if (i_text_byte < CTRL_END) begin
                n_s1.half_idx = 8'd0;
            end else if (i_text_byte < ASCII_END) begin
                n_s1.half_idx = i_text_byte - ASCII_OFS;
            end else begin
                n_s1.half_idx = i_text_byte - KANA_OFS;
            end
        end
        if (accept) begin
            n_s1_valid = emit;
        end else if (i_take) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead     <= 8'd0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_lead <= n_lead;
            end
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

`default_nettype wire

### rtl/core/sjgi_glyph_map.sv
// combinational glyph mapping: shift-jis pair to euc, euc to font index with
// absent-range correction, and half-width pass-through; uses sjgi_pkg
`default_nettype none

module sjgi_glyph_map
    import sjgi_pkg::*;
(
    input  wire t_s1 i_s1,
    output t_glyph   o_glyph
);

    logic [7:0]         hi;
    logic [7:0]         d;
    logic [7:0]         lo;
    logic [7:0]         lo_adj;
    logic [15:0]        c1;
    logic [15:0]        c2;
    logic [15:0]        c3;
    logic signed [16:0] row;
    logic signed [16:0] col;
    logic signed [16:0] n_raw;
    logic signed [16:0] n_fin;
    logic [10:0]        sub;
    logic               in_gap;
    logic               missing;

    always_comb begin
        hi = (i_s1.lead >= LEAD_HI_MIN) ? (i_s1.lead - HIGH_SHIFT) : i_s1.lead;
        d  = hi - LEAD_BASE;
        lo = i_s1.trail;
        c1 = {d[6:0], 1'b0, lo};
        // trail bytes above 0x7f skip the 0x7f hole
        lo_adj = lo - {7'd0, lo[7]};
        if (lo[7]) begin
            c1 = c1 - 16'd1;
        end
        c2 = (lo_adj >= TRAIL_SPLIT) ? (c1 + TRAIL_UP) : (c1 - TRAIL_DOWN);
        c3 = c2 + EUC_OFS;

        row   = $signed({9'd0, c3[15:8]}) - $signed({9'd0, EUC_BASE});
        col   = $signed({9'd0, c3[7:0]}) - $signed({9'd0, EUC_BASE});
        n_raw = row * 17'(ROW_CELLS) + col;

        // ranges are sorted, so the last one passed holds the running total
        sub    = 11'd0;
        in_gap = 1'b0;
        for (int k = 0; k < ABSENT_RANGES; k++) begin
            if (c3 >= ABSENT_START[k]
                && c3 <= ABSENT_START[k] + {5'd0, ABSENT_COUNT[k]} - 16'd1) begin
                in_gap = 1'b1;
            end
            if (c3 > ABSENT_START[k] + {5'd0, ABSENT_COUNT[k]} - 16'd1) begin
                sub = ABSENT_CUM[k];
            end
        end
        n_fin   = n_raw - $signed({6'd0, sub});
        missing = in_gap || (n_fin < 17'sd0) || (n_fin >= 17'(FONT_GLYPHS));

        o_glyph.full = i_s1.full;
        if (i_s1.full) begin
            o_glyph.missing = missing;
            o_glyph.idx     = missing ? '0 : n_fin[IDX_W-1:0];
        end else begin
            o_glyph.missing = 1'b0;
            o_glyph.idx     = {{(IDX_W-8){1'b0}}, i_s1.half_idx};
        end
    end

endmodule

`default_nettype wire

### rtl/core/shift_jis_glyph_index_decoder.sv
// top level of the shift-jis glyph index decoder: byte front end, glyph map
// and result register; uses sjgi_pkg, sjgi_byte_front, sjgi_glyph_map
//
// usage
//   input channel: i_valid / o_ready with i_text_byte, one text byte per item
//   output channel: o_valid / i_ready with o_full_width, o_glyph_index and
//   o_glyph_missing, one glyph per character
//   a lead byte (0x80-0x9f, 0xe0-0xff) is held until the next nonzero byte,
//   which completes a full-width character; a zero byte drops a held lead
//   and ends the string without a result; other bytes give half-width glyphs
//   path: a byte that completes a character enters the input register at
//   the edge that accepts it and moves to the result register once that
//   register can load; the receiver takes it from the result register
//   throughput: one byte per cycle while o_ready is high; the whole
//   mapping sits between the input register and the result register
//   stall: while the receiver holds i_ready low the result register holds,
//   and one more item can still be taken into the input register; o_ready
//   drops only when both registers are full
//   reset: i_rst_n synchronous, active low; clears the held lead byte and
//   both valid flags
`default_nettype none

module shift_jis_glyph_index_decoder
    import sjgi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_text_byte,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_full_width,
    output logic [IDX_W-1:0]      o_glyph_index,
    output logic                  o_glyph_missing
);

    logic   s1_valid;
    t_s1    s1;
    t_glyph glyph;
    logic   take;
    logic   r_out_valid;
    logic   n_out_valid;
    t_glyph r_out;

    // result register can load when empty or being drained
    assign take = !r_out_valid || i_ready;

    sjgi_byte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_text_byte (i_text_byte),
        .i_take      (take),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1)
    );

    sjgi_glyph_map u_map (
        .i_s1    (s1),
        .o_glyph (glyph)
    );

    assign n_out_valid = take ? s1_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && s1_valid) begin
            r_out <= glyph;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_full_width    = r_out.full;
    assign o_glyph_index   = r_out.idx;
    assign o_glyph_missing = r_out.missing;

    // a missing glyph always reports index zero
    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_glyph_missing |-> o_glyph_index == '0)
        else $error("missing glyph with nonzero index");

    // half-width glyphs are never flagged missing
    a_half_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_full_width |-> !o_glyph_missing)
        else $error("half-width glyph flagged missing");

    // full-width index stays inside the font
    a_full_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_full_width |-> o_glyph_index < IDX_W'(FONT_GLYPHS))
        else $error("full-width index beyond font");

    // half-width index fits the half-width font
    a_half_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_full_width |-> o_glyph_index < IDX_W'(160))
        else $error("half-width index beyond font");

endmodule

`default_nettype wire
